### sv/dtq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int KEY_W = 64;

    typedef enum logic {
        OP_POST = 1'b0,
        OP_TAKE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_BUSY  = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_EMPTY = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        op_t         operation;
        logic [31:0] callback_key;
        logic [31:0] argument_key;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] task_callback;
        logic [31:0] task_argument;
    } rsp_t;

    typedef struct packed {
        logic shift;
        logic set_pend;
        logic clr_pend;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### sv/dtq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/dtq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module dtq_cell (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire dtq_pkg::cell_ctrl_t      ctrl,
    input  wire logic [dtq_pkg::KEY_W-1:0] cmp_key,
    input  wire logic [dtq_pkg::KEY_W-1:0] in_key,
    input  wire logic                     in_valid,
    input  wire logic                     in_pend,
    output logic      [dtq_pkg::KEY_W-1:0] key,
    output logic                          valid,
    output logic                          pend,
    output logic                          match
);

    logic [dtq_pkg::KEY_W-1:0] key_reg;
    logic                      valid_reg;
    logic                      pend_reg;
    logic                      valid_next;
    logic                      pend_next;

    assign match = valid_reg && (key_reg == cmp_key);
    assign key   = key_reg;
    assign valid = valid_reg;
    assign pend  = pend_reg;

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        if (ctrl.shift)
        begin
            valid_next = in_valid;
            pend_next  = in_pend;
        end
        else if (ctrl.set_pend && match)
        begin
            pend_next = 1'b1;
        end
        else if (ctrl.clr_pend && match)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            key_reg <= in_key;
        end
    end

endmodule

`default_nettype wire

### sv/dedup_task_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Deduplicating task queue. A request is taken when start is high and busy is
// low; busy then stays high for one cycle and the answer appears on result with
// done high for exactly one cycle, registered at the end of the execute state.
// The receiver cannot stall: done and result are valid for that one cycle only,
// and a new request may be started in that same cycle, but no new request is
// taken while busy with the last one. The request is registered as the ready
// FIFO head is read from its RAM; in the execute state the key is compared
// against every entry of the row of table cells at once and the cells and the
// FIFO are updated. New keys enter at the front of the cell row, every known
// entry moving one cell on. No clearing pass is needed after reset.
module dedup_task_queue #(
    parameter int CAPACITY = dtq_pkg::DEFAULT_CAPACITY
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire dtq_pkg::req_t request,
    output logic               busy,
    output logic               done,
    output dtq_pkg::rsp_t      result
);

    localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int SUMW = CNTW + 1;
    localparam int KW   = dtq_pkg::KEY_W;

    dtq_pkg::state_t     state_reg;
    dtq_pkg::state_t     state_next;
    dtq_pkg::req_t       req_reg;
    logic                done_reg;
    logic                done_next;
    dtq_pkg::rsp_t       result_reg;
    dtq_pkg::rsp_t       result_next;
    logic [IDXW-1:0]     head_reg;
    logic [IDXW-1:0]     head_next;
    logic [CNTW-1:0]     fill_reg;
    logic [CNTW-1:0]     fill_next;

    dtq_pkg::cell_ctrl_t ctrl;
    logic [KW-1:0]       req_key;
    logic [KW-1:0]       cmp_key;
    logic [KW-1:0]       head_key;
    logic [KW-1:0]       cell_key   [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] cell_pend;
    logic [CAPACITY-1:0] cell_match;
    logic                hit;
    logic                hit_pend;
    logic                table_full;

    logic                fifo_we;
    logic [SUMW-1:0]     tail_sum;
    logic [IDXW-1:0]     tail;

    assign req_key    = {req_reg.callback_key, req_reg.argument_key};
    assign cmp_key    = (req_reg.operation == dtq_pkg::OP_TAKE) ? head_key : req_key;
    assign hit        = |cell_match;
    assign hit_pend   = |(cell_match & cell_pend);
    assign table_full = cell_valid[CAPACITY-1];

    assign tail_sum = SUMW'(head_reg) + SUMW'(fill_reg);
    assign tail     = (tail_sum >= SUMW'(CAPACITY))
                      ? IDXW'(tail_sum - SUMW'(CAPACITY)) : IDXW'(tail_sum);

    assign busy   = (state_reg != dtq_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            if (g == 0)
            begin : g_front
                dtq_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (ctrl),
                    .cmp_key  (cmp_key),
                    .in_key   (req_key),
                    .in_valid (1'b1),
                    .in_pend  (1'b1),
                    .key      (cell_key[g]),
                    .valid    (cell_valid[g]),
                    .pend     (cell_pend[g]),
                    .match    (cell_match[g])
                );
            end
            else
            begin : g_rest
                dtq_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (ctrl),
                    .cmp_key  (cmp_key),
                    .in_key   (cell_key[g-1]),
                    .in_valid (cell_valid[g-1]),
                    .in_pend  (cell_pend[g-1]),
                    .key      (cell_key[g]),
                    .valid    (cell_valid[g]),
                    .pend     (cell_pend[g]),
                    .match    (cell_match[g])
                );
            end
        end
    endgenerate

    dtq_ram #(
        .WIDTH (KW),
        .DEPTH (CAPACITY)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (tail),
        .wdata (req_key),
        .raddr (head_reg),
        .rdata (head_key)
    );

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        ctrl        = '0;
        fifo_we     = 1'b0;
        case (state_reg)
            dtq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = dtq_pkg::S_EXEC;
                end
            end
            dtq_pkg::S_EXEC:
            begin
                state_next                = dtq_pkg::S_IDLE;
                done_next                 = 1'b1;
                result_next.task_callback = '0;
                result_next.task_argument = '0;
                if (req_reg.operation == dtq_pkg::OP_TAKE)
                begin
                    if (fill_reg == '0)
                    begin
                        result_next.status = dtq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        result_next.status        = dtq_pkg::STATUS_OK;
                        result_next.task_callback = head_key[KW-1:32];
                        result_next.task_argument = head_key[31:0];
                        ctrl.clr_pend             = 1'b1;
                        fill_next                 = fill_reg - 1'b1;
                        head_next = (head_reg == IDXW'(CAPACITY - 1))
                                    ? '0 : head_reg + 1'b1;
                    end
                end
                else if (hit)
                begin
                    if (hit_pend)
                    begin
                        result_next.status = dtq_pkg::STATUS_BUSY;
                    end
                    else
                    begin
                        result_next.status = dtq_pkg::STATUS_OK;
                        ctrl.set_pend      = 1'b1;
                        fifo_we            = 1'b1;
                        fill_next          = fill_reg + 1'b1;
                    end
                end
                else if (table_full)
                begin
                    result_next.status = dtq_pkg::STATUS_FULL;
                end
                else
                begin
                    result_next.status = dtq_pkg::STATUS_OK;
                    ctrl.shift         = 1'b1;
                    fifo_we            = 1'b1;
                    fill_next          = fill_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = dtq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtq_pkg::S_IDLE;
            done_reg  <= 1'b0;
            head_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
        result_reg <= result_next;
    end

endmodule

`default_nettype wire
